// ===== rtl/core/ts_audio_pes_demux_defines.svh =====
// ----------------------------------------------------------------------------
// ts_audio_pes_demux_defines
// Assertion macros for the transport-stream audio demultiplexer.
// ----------------------------------------------------------------------------
`ifndef TS_AUDIO_PES_DEMUX_DEFINES_SVH
`define TS_AUDIO_PES_DEMUX_DEFINES_SVH
`ifndef SYNTH
`define TSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tsad_pkg.sv =====
// ----------------------------------------------------------------------------
// tsad_pkg
// Types and constants shared by the audio demultiplexer modules.
// ----------------------------------------------------------------------------
package tsad_pkg;

    localparam logic [7:0] PKT_LEN   = 8'd188;
    localparam logic [7:0] SYNC_BYTE = 8'h47;

    typedef enum logic [1:0] {
        ROLE_NONE  = 2'd0,
        ROLE_PAT   = 2'd1,
        ROLE_PMT   = 2'd2,
        ROLE_AUDIO = 2'd3
    } t_role;

    // One result transaction as produced by the parser.
    typedef struct packed {
        logic        kind;
        logic [7:0]  audio_byte;
        logic [12:0] es_pid;
        logic        pes_start;
    } t_result;

    function automatic logic is_audio_type(input logic [7:0] t);
        return (t == 8'h0F) || (t == 8'h11) || (t == 8'h03) || (t == 8'h04);
    endfunction

    function automatic logic [9:0] sat10(input logic [13:0] v);
        return (v > 14'd1023) ? 10'd1023 : v[9:0];
    endfunction

endpackage

// ===== rtl/core/tsad_parser.sv =====
// ----------------------------------------------------------------------------
// tsad_parser
// Byte parser: holds all stream state in registers and, while enabled,
// turns one byte a cycle into at most one result.
// ----------------------------------------------------------------------------
`include "ts_audio_pes_demux_defines.svh"
module tsad_parser
    import tsad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]  r_byte_index, n_byte_index;
    logic        r_hunting, n_hunting;
    logic        r_halted, n_halted;
    logic [12:0] r_packet_pid, n_packet_pid;
    logic        r_unit_start, n_unit_start;
    logic [1:0]  r_adapt, n_adapt;
    logic [7:0]  r_hdr_len, n_hdr_len;
    logic [8:0]  r_sec_off, n_sec_off;
    logic [11:0] r_sec_len, n_sec_len;
    logic [11:0] r_pil, n_pil;
    logic [9:0]  r_next_off, n_next_off;
    logic [7:0]  r_entry_type, n_entry_type;
    logic [12:0] r_entry_pid, n_entry_pid;
    logic [12:0] r_table_pid, n_table_pid;
    logic        r_table_valid, n_table_valid;
    logic [12:0] r_es_pid, n_es_pid;
    logic        r_audio_found, n_audio_found;
    logic [8:0]  r_pes_end, n_pes_end;
    logic        r_prefix_ok, n_prefix_ok;
    t_role       r_role, n_role;

    // Working values for the current byte.
    logic        res_v;
    t_result     res;
    logic [7:0]  q;
    logic [7:0]  plen;
    logic [8:0]  tbl_pos;
    logic [9:0]  d;
    logic [8:0]  new_off;
    logic [8:0]  p1;
    t_role       role0;

    always_comb begin
        n_byte_index = r_byte_index; n_hunting = r_hunting; n_halted = r_halted;
        n_packet_pid = r_packet_pid; n_unit_start = r_unit_start; n_adapt = r_adapt;
        n_hdr_len = r_hdr_len; n_sec_off = r_sec_off; n_sec_len = r_sec_len;
        n_pil = r_pil; n_next_off = r_next_off; n_entry_type = r_entry_type;
        n_entry_pid = r_entry_pid; n_table_pid = r_table_pid;
        n_table_valid = r_table_valid; n_es_pid = r_es_pid;
        n_audio_found = r_audio_found; n_pes_end = r_pes_end;
        n_prefix_ok = r_prefix_ok; n_role = r_role;
        res_v = 1'b0;
        res = '{kind: 1'b0, audio_byte: i_byte, es_pid: r_es_pid, pes_start: 1'b0};
        q = r_byte_index - r_hdr_len;
        plen = PKT_LEN - r_hdr_len;
        tbl_pos = {1'b0, q} - r_sec_off;
        d = {1'b0, tbl_pos} - r_next_off;
        new_off = {1'b0, i_byte} + 9'd1;
        p1 = {1'b0, r_byte_index} + 9'd1;
        role0 = ROLE_NONE;
        if (i_en && !r_halted) begin
            if (r_hunting) begin
                if (i_byte == SYNC_BYTE) begin
                    n_hunting = 1'b0;
                    n_byte_index = 8'd1;
                end
            end else begin
                // Header fields and adaptation field.
                if (r_byte_index == 8'd1) begin
                    n_packet_pid = {i_byte[4:0], 8'd0};
                    n_unit_start = i_byte[6];
                end else if (r_byte_index == 8'd2) begin
                    n_packet_pid = {r_packet_pid[12:8], i_byte};
                end else if (r_byte_index == 8'd3) begin
                    n_adapt = i_byte[5:4];
                    n_hdr_len = 8'd4;
                    n_role = ROLE_NONE;
                end else if (r_byte_index >= 8'd4) begin
                    if (r_byte_index == 8'd4 && r_adapt[1]) begin
                        if (i_byte > PKT_LEN - 8'd5) n_halted = 1'b1;
                        else n_hdr_len = i_byte + 8'd5;
                    end else if (r_adapt[0] && r_byte_index >= r_hdr_len) begin
                        if (q == 8'd0) begin
                            // First payload byte picks the packet role.
                            if (r_packet_pid == 13'd0 && r_unit_start && !r_audio_found)
                                role0 = ROLE_PAT;
                            else if (r_table_valid && r_table_pid != 13'd0 &&
                                     r_packet_pid == r_table_pid && r_unit_start &&
                                     !r_audio_found)
                                role0 = ROLE_PMT;
                            else if (r_audio_found && r_es_pid != 13'd0 &&
                                     r_packet_pid == r_es_pid)
                                role0 = ROLE_AUDIO;
                            n_role = role0;
                            if (role0 == ROLE_PAT || role0 == ROLE_PMT) begin
                                n_sec_off = new_off;
                                if ({1'b0, new_off} + ((role0 == ROLE_PAT) ? 10'd8 : 10'd12)
                                    >= {2'b0, plen})
                                    n_role = ROLE_NONE;
                            end else if (role0 == ROLE_AUDIO) begin
                                if (r_unit_start) n_prefix_ok = (i_byte == 8'd0);
                                else res_v = 1'b1;
                            end
                        end else if (r_role == ROLE_AUDIO) begin
                            if (!r_unit_start) res_v = 1'b1;
                            else if (q == 8'd1) n_prefix_ok = r_prefix_ok & (i_byte == 8'd0);
                            else if (q == 8'd2) n_prefix_ok = r_prefix_ok & (i_byte == 8'd1);
                            else if (q == 8'd8) n_pes_end = {1'b0, i_byte} + 9'd9;
                            else if (q >= 8'd9 && r_prefix_ok && {1'b0, q} >= r_pes_end) begin
                                res_v = 1'b1;
                                res.pes_start = ({1'b0, q} == r_pes_end);
                            end
                        end else if ((r_role == ROLE_PAT || r_role == ROLE_PMT) &&
                                     {1'b0, q} >= r_sec_off) begin
                            // Section parsing for the PAT and the PMT.
                            if (tbl_pos == 9'd0) begin
                                if (i_byte != ((r_role == ROLE_PAT) ? 8'h00 : 8'h02))
                                    n_role = ROLE_NONE;
                            end else if (tbl_pos == 9'd1) begin
                                n_sec_len = {i_byte[3:0], 8'd0};
                            end else if (tbl_pos == 9'd2) begin
                                n_sec_len = {r_sec_len[11:8], i_byte};
                            end else if (r_role == ROLE_PAT) begin
                                if (tbl_pos == 9'd10) begin
                                    n_entry_pid = {i_byte[4:0], 8'd0};
                                end else if (tbl_pos == 9'd11) begin
                                    if (r_sec_len >= 12'd9) begin
                                        n_table_pid = r_entry_pid | {5'd0, i_byte};
                                        n_table_valid = 1'b1;
                                    end
                                    n_role = ROLE_NONE;
                                end
                            end else begin
                                if (tbl_pos == 9'd10) begin
                                    n_pil = {i_byte[3:0], 8'd0};
                                end else if (tbl_pos == 9'd11) begin
                                    n_pil = {r_pil[11:8], i_byte};
                                    n_next_off = sat10(14'd12 + {2'd0, r_pil[11:8], i_byte});
                                end else if (tbl_pos >= 9'd12 &&
                                             {1'b0, tbl_pos} >= r_next_off) begin
                                    if (d == 10'd0) begin
                                        if ({2'b0, r_next_off} + 12'd6 <= r_sec_len)
                                            n_entry_type = i_byte;
                                        else
                                            n_role = ROLE_NONE;
                                    end else if (d == 10'd1) begin
                                        n_entry_pid = {i_byte[4:0], 8'd0};
                                    end else if (d == 10'd2) begin
                                        n_entry_pid = r_entry_pid | {5'd0, i_byte};
                                    end else if (d == 10'd3) begin
                                        n_pil = {8'd0, i_byte[3:0]};
                                    end else if (d == 10'd4) begin
                                        if (is_audio_type(r_entry_type)) begin
                                            n_audio_found = 1'b1;
                                            n_es_pid = r_entry_pid;
                                            n_role = ROLE_NONE;
                                            res_v = 1'b1;
                                            res = '{kind: 1'b1, audio_byte: 8'd0,
                                                    es_pid: r_entry_pid, pes_start: 1'b0};
                                        end else begin
                                            n_next_off = sat10({4'd0, r_next_off} + 14'd5 +
                                                {2'd0, r_pil[3:0], i_byte});
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                // Packet byte counter.
                if (!(r_byte_index == 8'd4 && r_adapt[1] && i_byte > PKT_LEN - 8'd5)) begin
                    if (p1 >= {1'b0, PKT_LEN}) begin
                        n_hunting = 1'b1;
                        n_byte_index = 8'd0;
                    end else begin
                        n_byte_index = p1[7:0];
                    end
                end
            end
        end
        // End of chunk clears the per-chunk state.
        if (i_en && i_last) begin
            n_table_pid = 13'd0; n_table_valid = 1'b0; n_hunting = 1'b1;
            n_byte_index = 8'd0; n_halted = 1'b0; n_role = ROLE_NONE;
        end
    end

    assign o_res_valid = res_v;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0; r_hunting <= 1'b1; r_halted <= 1'b0;
            r_packet_pid <= '0; r_unit_start <= 1'b0; r_adapt <= '0;
            r_hdr_len <= 8'd4; r_sec_off <= '0; r_sec_len <= '0; r_pil <= '0;
            r_next_off <= '0; r_entry_type <= '0; r_entry_pid <= '0;
            r_table_pid <= '0; r_table_valid <= 1'b0; r_es_pid <= '0;
            r_audio_found <= 1'b0; r_pes_end <= '0; r_prefix_ok <= 1'b0;
            r_role <= ROLE_NONE;
        end else begin
            r_byte_index <= n_byte_index; r_hunting <= n_hunting; r_halted <= n_halted;
            r_packet_pid <= n_packet_pid; r_unit_start <= n_unit_start; r_adapt <= n_adapt;
            r_hdr_len <= n_hdr_len; r_sec_off <= n_sec_off; r_sec_len <= n_sec_len;
            r_pil <= n_pil; r_next_off <= n_next_off; r_entry_type <= n_entry_type;
            r_entry_pid <= n_entry_pid; r_table_pid <= n_table_pid;
            r_table_valid <= n_table_valid; r_es_pid <= n_es_pid;
            r_audio_found <= n_audio_found; r_pes_end <= n_pes_end;
            r_prefix_ok <= n_prefix_ok; r_role <= n_role;
        end
    end

    // The packet counter never reaches the packet length.
    `TSA_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1, r_byte_index < PKT_LEN)
    // While hunting, the counter rests at zero.
    `TSA_ASSERT_IMP(a_hunt_idx, i_clk, i_rst_n, r_hunting, r_byte_index == 8'd0)
    // Once found, the audio PID stays found.
    `TSA_ASSERT_NEXT(a_found_sticky, i_clk, i_rst_n, r_audio_found, r_audio_found)
    // Nothing leaves while halted.
    `TSA_ASSERT_IMP(a_halt_quiet, i_clk, i_rst_n, r_halted, !res_v)

endmodule

// ===== rtl/core/tsad_out_buf.sv =====
// ----------------------------------------------------------------------------
// tsad_out_buf
// Two-entry output buffer with a skid slot, so the parser keeps going while
// one result waits; input ready falls once both slots are full.
// ----------------------------------------------------------------------------
`include "ts_audio_pes_demux_defines.svh"
module tsad_out_buf
    import tsad_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_v0, r_v1;
    t_result r_d0, r_d1;

    assign o_ready = !r_v1;
    assign o_valid = r_v0;
    assign o_data  = r_d0;

    // Head slot feeds the port; the skid slot holds overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (!r_v0 || i_ready) begin
                if (r_v1) begin
                    r_v0 <= 1'b1; r_d0 <= r_d1;
                    r_v1 <= i_valid && o_ready; r_d1 <= i_data;
                end else begin
                    r_v0 <= i_valid; r_d0 <= i_data;
                end
            end else if (i_valid && o_ready) begin
                r_v1 <= 1'b1; r_d1 <= i_data;
            end
        end
    end

    `TSA_ASSERT_IMP(a_skid_order, i_clk, i_rst_n, r_v1, r_v0)
    `TSA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_v0 && !i_ready, r_v0 && $stable(r_d0))
    `TSA_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, r_v1 && r_v0 && !i_ready, r_v1)

endmodule

// ===== rtl/core/ts_audio_pes_demux.sv =====
// ----------------------------------------------------------------------------
// ts_audio_pes_demux
// Extracts the first AAC or MP3 audio stream from a transport stream.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per transaction, with a flag on the last
// byte of a chunk. Output channel: at most one result per input byte, either
// a one-off notice of the detected audio PID or an audio payload byte.
// Each accepted byte is handled by the parser, whose state registers
// hold the sync hunt, packet counter, header fields and table progress; the
// result is captured into the head slot of the two-entry output buffer,
// or into the skid slot while the head waits. Throughput is one byte per
// cycle while input ready is high. When the receiver stalls, the buffer
// absorbs one more result and then input ready falls until the head is
// taken; nothing is dropped. Reset is synchronous and active low: it returns
// the parser to sync hunt and empties the output buffer, so ready is high.
// ----------------------------------------------------------------------------
module ts_audio_pes_demux
    import tsad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_chunk,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_audio_byte,
    output logic [12:0] o_es_pid,
    output logic        o_pes_start
);

    logic    acc;
    logic    res_v;
    t_result res;
    t_result out_d;

    assign acc = i_valid && o_ready;

    tsad_parser u_parser (
        .i_clk, .i_rst_n, .i_en(acc), .i_byte(i_data_byte), .i_last(i_last_of_chunk),
        .o_res_valid(res_v), .o_res(res)
    );

    tsad_out_buf u_buf (
        .i_clk, .i_rst_n, .i_valid(res_v), .i_data(res), .o_ready(o_ready),
        .o_valid(o_valid), .o_data(out_d), .i_ready(i_ready)
    );

    assign o_kind       = out_d.kind;
    assign o_audio_byte = out_d.audio_byte;
    assign o_es_pid     = out_d.es_pid;
    assign o_pes_start  = out_d.pes_start;

endmodule

// ===== tb/ts_audio_pes_demux_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_audio_pes_demux_test
// Self-checking bench for the transport-stream audio demultiplexer. Builds
// PAT, PMT and audio PES packets with random content, mixes in noise and
// broken packets, and compares every output transaction with a predictor.
// ----------------------------------------------------------------------------
module ts_audio_pes_demux_test
    import tsad_pkg::*;
();

    // Predictor of the demultiplexer and store of the results it expects.
    class demux_scoreboard;
        int unsigned pos;
        bit          hunting, halted, ustart, tpid_ok, apid_ok, prefix_ok;
        logic [12:0] pkt_pid, entry_pid, tpid, apid;
        logic [1:0]  afc;
        int unsigned hdr_len, sec_off, sec_len, pil, next_off, pes_end;
        logic [7:0]  stype;
        t_role       role;
        t_result     pending[$];
        int          mismatches;

        function void clear();
            pos = 0; hunting = 1'b1; halted = 1'b0; pkt_pid = '0; ustart = 1'b0;
            afc = '0; hdr_len = 4; sec_off = 0; sec_len = 0; pil = 0; next_off = 0;
            stype = '0; entry_pid = '0; tpid = '0; tpid_ok = 1'b0; apid = '0;
            apid_ok = 1'b0; pes_end = 0; prefix_ok = 1'b0; role = ROLE_NONE;
            pending.delete(); mismatches = 0;
        endfunction

        function void push(bit k, logic [7:0] b, bit st);
            t_result r;
            r.kind = k; r.audio_byte = b; r.es_pid = apid; r.pes_start = st;
            pending.push_back(r);
        endfunction

        function bit audio_type(logic [7:0] t);
            return t == 8'h0F || t == 8'h11 || t == 8'h03 || t == 8'h04;
        endfunction

        function void table_byte(int unsigned q, logic [7:0] b);
            int unsigned r, d;
            if (q < sec_off) return;
            r = q - sec_off;
            if (r == 0) begin
                if (b != (role == ROLE_PAT ? 8'h00 : 8'h02)) role = ROLE_NONE;
            end else if (r == 1) begin
                sec_len = {20'd0, b[3:0], 8'd0};
            end else if (r == 2) begin
                sec_len |= 32'(b);
            end else if (role == ROLE_PAT) begin
                if (r == 10) begin
                    entry_pid = {b[4:0], 8'h00};
                end else if (r == 11) begin
                    if (sec_len >= 9) begin
                        tpid = entry_pid | {5'd0, b}; tpid_ok = 1'b1;
                    end
                    role = ROLE_NONE;
                end
            end else begin
                if (r == 10) begin
                    pil = {20'd0, b[3:0], 8'd0};
                end else if (r == 11) begin
                    pil |= 32'(b);
                    next_off = (12 + pil > 1023) ? 1023 : 12 + pil;
                end else if (r >= 12 && r >= next_off) begin
                    d = r - next_off;
                    if (d == 0) begin
                        if (next_off + 6 <= sec_len) stype = b;
                        else role = ROLE_NONE;
                    end else if (d == 1) begin
                        entry_pid = {b[4:0], 8'h00};
                    end else if (d == 2) begin
                        entry_pid |= {5'd0, b};
                    end else if (d == 3) begin
                        pil = 32'(b[3:0]);
                    end else if (d == 4) begin
                        if (audio_type(stype)) begin
                            apid_ok = 1'b1; apid = entry_pid; role = ROLE_NONE;
                            push(1'b1, 8'd0, 1'b0);
                            return;
                        end
                        next_off = next_off + 5 + ((pil << 8) | 32'(b));
                        if (next_off > 1023) next_off = 1023;
                    end
                end
            end
        endfunction

        function void payload_byte(int unsigned q, logic [7:0] b);
            int unsigned plen;
            if (q == 0) begin
                plen = 188 - hdr_len;
                if (pkt_pid == 13'd0 && ustart && !apid_ok) role = ROLE_PAT;
                else if (tpid_ok && tpid != 13'd0 && pkt_pid == tpid && ustart && !apid_ok)
                    role = ROLE_PMT;
                else if (apid_ok && apid != 13'd0 && pkt_pid == apid) role = ROLE_AUDIO;
                else role = ROLE_NONE;
                if (role == ROLE_PAT || role == ROLE_PMT) begin
                    sec_off = 32'(b) + 1;
                    if (sec_off + (role == ROLE_PAT ? 8 : 12) >= plen) role = ROLE_NONE;
                end else if (role == ROLE_AUDIO) begin
                    if (ustart) prefix_ok = (b == 8'd0);
                    else push(1'b0, b, 1'b0);
                end
                return;
            end
            if (role == ROLE_AUDIO) begin
                if (!ustart) push(1'b0, b, 1'b0);
                else if (q == 1) prefix_ok &= (b == 8'd0);
                else if (q == 2) prefix_ok &= (b == 8'd1);
                else if (q == 8) pes_end = 32'(b) + 9;
                else if (q >= 9 && prefix_ok && q >= pes_end) push(1'b0, b, q == pes_end);
            end else if (role == ROLE_PAT || role == ROLE_PMT) begin
                table_byte(q, b);
            end
        endfunction

        // Notes one accepted input transaction.
        function void note_input(logic [7:0] b, bit last);
            int unsigned p;
            if (!halted) begin
                if (hunting) begin
                    if (b == SYNC_BYTE) begin
                        hunting = 1'b0; pos = 1;
                    end
                end else begin
                    p = pos;
                    if (p == 1) begin
                        pkt_pid = {b[4:0], 8'h00}; ustart = b[6];
                    end else if (p == 2) begin
                        pkt_pid |= {5'd0, b};
                    end else if (p == 3) begin
                        afc = b[5:4]; hdr_len = 4; role = ROLE_NONE;
                    end else if (p == 4 && afc[1]) begin
                        if (b > 8'd183) halted = 1'b1;
                        else hdr_len = 32'(b) + 5;
                    end else if (p >= 4 && afc[0] && p >= hdr_len) begin
                        payload_byte(p - hdr_len, b);
                    end
                    if (!halted) begin
                        p++;
                        if (p >= 188) begin
                            hunting = 1'b1; pos = 0;
                        end else begin
                            pos = p;
                        end
                    end
                end
            end
            if (last) begin
                tpid = '0; tpid_ok = 1'b0; hunting = 1'b1; pos = 0; halted = 1'b0;
                role = ROLE_NONE;
            end
        endfunction

        // Checks one output transaction against the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d byte=%02h pid=%0d st=%0d",
                             got.kind, got.audio_byte, got.es_pid, got.pes_start);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("exp k=%0d b=%02h pid=%0d st=%0d got k=%0d b=%02h pid=%0d st=%0d",
                             want.kind, want.audio_byte, want.es_pid, want.pes_start,
                             got.kind, got.audio_byte, got.es_pid, got.pes_start);
            end
        endfunction
    endclass

    logic        clk = 1'b0, rst_n = 1'b0;
    logic        in_valid = 1'b0, out_ready = 1'b0, in_last = 1'b0;
    logic [7:0]  in_byte = 8'd0;
    logic        in_ready, out_valid, o_kind, o_pes_start;
    logic [7:0]  o_audio_byte;
    logic [12:0] o_es_pid;
    demux_scoreboard sb;
    bit          stim_done = 1'b0;
    logic [7:0]  pkt[188];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ts_audio_pes_demux DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_data_byte(in_byte), .i_last_of_chunk(in_last), .o_valid(out_valid),
        .i_ready(out_ready), .o_kind(o_kind), .o_audio_byte(o_audio_byte),
        .o_es_pid(o_es_pid), .o_pes_start(o_pes_start)
    );

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Picks a nonzero PID, often the largest one.
    function automatic logic [12:0] pick_pid();
        if ($urandom_range(0, 3) == 0) return 13'd8191;
        return 13'($urandom_range(1, 8190));
    endfunction

    // Monitor of both channels.
    always @(posedge clk) begin
        t_result got;
        if (rst_n && out_valid && out_ready) begin
            got.kind = o_kind; got.audio_byte = o_audio_byte;
            got.es_pid = o_es_pid; got.pes_start = o_pes_start;
            sb.check_result(got);
        end
        if (rst_n && in_valid && in_ready) sb.note_input(in_byte, in_last);
    end

    // Receiver with random stalls.
    initial begin
        int unsigned g;
        wait (rst_n);
        forever begin
            g = gap_len();
            if (g != 0) begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Sends one byte, with an optional idle gap before it.
    task automatic send_byte(logic [7:0] b, bit last);
        int unsigned g;
        g = gap_len();
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1; in_byte <= b; in_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_packet(bit last_on_end, int unsigned cut);
        for (int i = 0; i < 188 && i < cut; i++)
            send_byte(pkt[i], last_on_end && (i == 187 || i + 1 == cut));
    endtask

    task automatic fill_random();
        foreach (pkt[i]) pkt[i] = 8'($urandom);
    endtask

    // TS header with optional adaptation field of length alen (255 = none).
    task automatic header(logic [12:0] pid, bit pusi, int unsigned alen);
        pkt[0] = SYNC_BYTE;
        pkt[1] = {1'b0, pusi, 1'b0, pid[12:8]};
        pkt[2] = pid[7:0];
        pkt[3] = {2'b00, (alen == 255) ? 2'b01 : 2'b11, 4'($urandom)};
        if (alen != 255) pkt[4] = 8'(alen);
    endtask

    task automatic make_pat(logic [12:0] pmt, int unsigned ptr, int unsigned slen);
        int unsigned s;
        fill_random();
        header(13'd0, 1'b1, 255);
        pkt[4] = 8'(ptr);
        s = 5 + ptr;
        pkt[s] = 8'h00; pkt[s+1] = {4'hB, 4'(slen >> 8)}; pkt[s+2] = 8'(slen);
        if (s + 11 < 188) begin
            pkt[s+10] = {3'b111, pmt[12:8]}; pkt[s+11] = pmt[7:0];
        end
    endtask

    task automatic make_pmt(logic [12:0] pid, logic [12:0] apid, logic [7:0] atype,
                            int unsigned nfill);
        int unsigned s, e;
        logic [7:0] t;
        fill_random();
        header(pid, 1'b1, 255);
        pkt[4] = 8'($urandom_range(0, 2));
        s = 5 + 32'(pkt[4]);
        pkt[s] = 8'h02; pkt[s+1] = 8'hB0; pkt[s+2] = 8'd120;
        pkt[s+10] = 8'hF0; pkt[s+11] = 8'($urandom_range(0, 4));
        e = s + 12 + 32'(pkt[s+11]);
        for (int k = 0; k < nfill; k++) begin
            t = ($urandom_range(0, 1) != 0) ? 8'h1B : 8'h02;
            pkt[e] = t; pkt[e+1] = 8'hE1; pkt[e+2] = 8'($urandom);
            pkt[e+3] = 8'hF0; pkt[e+4] = 8'($urandom_range(0, 3));
            e = e + 5 + 32'(pkt[e+4]);
        end
        pkt[e] = atype; pkt[e+1] = {3'b111, apid[12:8]}; pkt[e+2] = apid[7:0];
        pkt[e+3] = 8'hF0; pkt[e+4] = 8'h00;
    endtask

    task automatic make_audio(logic [12:0] pid, bit pusi, bit good_prefix, int unsigned hlen);
        int unsigned s, alen;
        fill_random();
        alen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : 255;
        header(pid, pusi, alen);
        if (pusi) begin
            s = (pkt[3][5]) ? 5 + 32'(pkt[4]) : 4;
            pkt[s] = 8'd0; pkt[s+1] = 8'd0; pkt[s+2] = good_prefix ? 8'h01 : 8'h02;
            pkt[s+3] = 8'hC0; pkt[s+8] = 8'(hlen);
        end
    endtask

    // One chunk: PAT, PMT, then audio packets, with some noise.
    task automatic send_chunk(int unsigned naudio, logic [12:0] pmt, logic [12:0] apid);
        logic [7:0]  types[4];
        int unsigned nnoise;
        types = '{8'h0F, 8'h11, 8'h03, 8'h04};
        nnoise = $urandom_range(0, 3);
        for (int i = 0; i < nnoise; i++) send_byte(8'($urandom), 1'b0);
        make_pat(pmt, $urandom_range(0, 3), 13);
        send_packet(1'b0, 188);
        make_pmt(pmt, apid, types[2'($urandom_range(0, 3))], $urandom_range(0, 3));
        send_packet(1'b0, 188);
        for (int k = 0; k < naudio; k++) begin
            make_audio(apid, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0,
                       ($urandom_range(0, 9) != 0) ? $urandom_range(0, 10) : 200);
            send_packet(k == naudio - 1,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(5, 187) : 188);
        end
    endtask

    initial begin
        logic [12:0] pmt_pid, aud_pid;
        sb = new();
        sb.clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise, bad adaptation length, pointer past the packet,
        // and a section too short to give a PMT PID.
        send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(SYNC_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
        fill_random(); header(13'd5, 1'b1, 200); send_packet(1'b1, 24);
        make_pat(13'd32, 176, 13); send_packet(1'b1, 8);
        make_pat(13'd32, 0, 5); send_packet(1'b1, 40);

        // A chunk that finds the audio stream, then a foreign packet.
        pmt_pid = pick_pid();
        aud_pid = pick_pid();
        send_chunk(2, pmt_pid, aud_pid);
        fill_random(); header(13'($urandom), 1'($urandom_range(0, 1)), 255);
        send_packet(1'b1, 188);

        in_valid <= 1'b0; in_last <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== ts_audio_pes_demux.f =====
+incdir+rtl/core
rtl/core/tsad_pkg.sv
rtl/core/tsad_parser.sv
rtl/core/tsad_out_buf.sv
rtl/core/ts_audio_pes_demux.sv
tb/ts_audio_pes_demux_test.sv
